[hdl/scfd_pkg.sv]
// shared types and constants for the serial can frame deframer
`default_nettype none

package scfd_pkg;

    localparam int WINDOW_DEPTH   = 20;
    localparam int MIN_CHECK_FILL = 13;

    localparam int IDX_W = $clog2(WINDOW_DEPTH);
    localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
    localparam int LEN_W = 5;
    localparam int CMP_W = (FILL_W > LEN_W) ? FILL_W : LEN_W;
    localparam int WORD_W = 32;
    localparam int CFG_IDX_W = 1;

    localparam logic [7:0] SOF_BYTE  = 8'hAA;
    localparam logic [7:0] TYPE_MASK = 8'hC0;
    localparam logic [7:0] LEN_MASK  = 8'h0F;
    localparam logic [7:0] EOF_BYTE  = 8'h55;

    localparam logic [LEN_W-1:0] HDR_LEN = LEN_W'(5);
    localparam logic [3:0]       MIN_DLC = 4'd8;

    localparam logic [WORD_W-1:0] START_RESET = WORD_W'(123456789);
    localparam logic [WORD_W-1:0] END_RESET   = WORD_W'(987654321);

    localparam logic [CFG_IDX_W-1:0] CFG_START_MARKER = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_MARKER   = 1'b1;

    typedef enum logic [1:0] {
        KIND_START   = 2'd0,
        KIND_END     = 2'd1,
        KIND_IN_SES  = 2'd2,
        KIND_OUT_SES = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        CHK_DONE  = 2'd0,
        CHK_DROP1 = 2'd1,
        CHK_SHORT = 2'd2,
        CHK_FRAME = 2'd3
    } t_chk;

    typedef enum logic [2:0] {
        S_IDLE      = 3'd0,
        S_CHECK     = 3'd1,
        S_DROP      = 3'd2,
        S_DROP_EMIT = 3'd3,
        S_EMIT      = 3'd4
    } t_state;

    typedef struct packed {
        logic append;
        logic drop_one;
        logic load_cnt;
        logic dec_cnt;
        logic capture;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        t_chk chk;
        logic drop_last;
        logic out_free;
    } t_stat;

endpackage

`default_nettype wire

[hdl/scfd_ctrl.sv]
// controller state machine for the frame deframer
`default_nettype none

module scfd_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  wire scfd_pkg::t_stat i_stat,
    output scfd_pkg::t_cmd     o_cmd
);
    import scfd_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_valid) n_state = S_CHECK;
            end
            S_CHECK: begin
                case (i_stat.chk)
                    CHK_DONE:  n_state = S_IDLE;
                    CHK_DROP1: n_state = S_CHECK;
                    CHK_SHORT: n_state = S_DROP;
                    CHK_FRAME: n_state = S_DROP_EMIT;
                    default:   n_state = S_IDLE;
                endcase
            end
            S_DROP: begin
                if (i_stat.drop_last) n_state = S_CHECK;
            end
            S_DROP_EMIT: begin
                if (i_stat.drop_last) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (i_stat.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd   = '0;
        o_stall = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall      = 1'b0;
                o_cmd.append = i_valid;
            end
            S_CHECK: begin
                case (i_stat.chk)
                    CHK_DROP1: o_cmd.drop_one = 1'b1;
                    CHK_SHORT: begin
                        o_cmd.drop_one = 1'b1;
                        o_cmd.load_cnt = 1'b1;
                    end
                    CHK_FRAME: begin
                        o_cmd.drop_one = 1'b1;
                        o_cmd.load_cnt = 1'b1;
                        o_cmd.capture  = 1'b1;
                    end
                    default: o_cmd.drop_one = 1'b0;
                endcase
            end
            S_DROP, S_DROP_EMIT: begin
                o_cmd.drop_one = 1'b1;
                o_cmd.dec_cnt  = 1'b1;
            end
            S_EMIT: begin
                o_cmd.load_out = i_stat.out_free;
            end
            default: o_stall = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

[hdl/scfd_dpath.sv]
// byte window, frame check, session tracking and output register
`default_nettype none

module scfd_dpath (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [7:0]                    i_rx_byte,
    input  wire logic                          i_cfg_valid,
    input  wire logic [scfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [scfd_pkg::WORD_W-1:0]   i_cfg_data,
    input  wire logic                          i_stall,
    input  wire scfd_pkg::t_cmd                i_cmd,
    output scfd_pkg::t_stat                    o_stat,
    output logic                               o_valid,
    output logic [scfd_pkg::WORD_W-1:0]        o_first_word,
    output logic [scfd_pkg::WORD_W-1:0]        o_second_word,
    output logic                               o_second_present,
    output logic [1:0]                         o_frame_kind
);
    import scfd_pkg::*;

    logic [7:0]        r_win [WINDOW_DEPTH];
    logic [FILL_W-1:0] r_fill;
    logic [LEN_W-1:0]  r_drop_cnt;
    logic              r_in_session;
    logic [WORD_W-1:0] r_start_marker;
    logic [WORD_W-1:0] r_end_marker;
    logic [WORD_W-1:0] r_pend_a;
    logic [WORD_W-1:0] r_pend_b;
    t_kind             r_pend_kind;
    logic              r_out_valid;
    logic [WORD_W-1:0] r_out_a;
    logic [WORD_W-1:0] r_out_b;
    logic              r_out_present;
    t_kind             r_out_kind;

    logic              full;
    logic [CMP_W-1:0]  fill_c;
    logic [3:0]        dlc;
    logic [LEN_W-1:0]  flen;
    logic [LEN_W-1:0]  flen_m1;
    logic [7:0]        eof_byte;
    logic [7:0]        type_byte;
    logic [WORD_W-1:0] word_a;
    logic [WORD_W-1:0] word_b;
    t_chk              chk;
    t_kind             kind;
    logic              out_free;

    assign full      = (r_fill == FILL_W'(WINDOW_DEPTH));
    assign fill_c    = CMP_W'(r_fill);
    assign type_byte = r_win[1];
    assign dlc       = 4'(type_byte & LEN_MASK);
    assign flen      = HDR_LEN + LEN_W'(dlc);
    assign flen_m1   = flen - LEN_W'(1);
    assign word_a    = {r_win[7], r_win[6], r_win[5], r_win[4]};
    assign word_b    = {r_win[11], r_win[10], r_win[9], r_win[8]};
    assign out_free  = !r_out_valid || !i_stall;

    always_comb begin
        eof_byte = 8'h00;
        for (int i = 0; i < WINDOW_DEPTH; i++) begin
            if (LEN_W'(i) == flen_m1) eof_byte = r_win[i];
        end
    end

    always_comb begin
        if (fill_c < CMP_W'(MIN_CHECK_FILL)) begin
            chk = CHK_DONE;
        end else if (r_win[0] != SOF_BYTE) begin
            chk = CHK_DROP1;
        end else if ((type_byte & TYPE_MASK) != TYPE_MASK) begin
            chk = CHK_DROP1;
        end else if (fill_c < CMP_W'(flen)) begin
            chk = full ? CHK_DROP1 : CHK_DONE;
        end else if (eof_byte != EOF_BYTE) begin
            chk = CHK_DROP1;
        end else if (dlc < MIN_DLC) begin
            chk = CHK_SHORT;
        end else begin
            chk = CHK_FRAME;
        end
    end

    always_comb begin
        if (word_a == r_start_marker) begin
            kind = KIND_START;
        end else if (word_a == r_end_marker) begin
            kind = KIND_END;
        end else if (r_in_session) begin
            kind = KIND_IN_SES;
        end else begin
            kind = KIND_OUT_SES;
        end
    end

    assign o_stat.chk       = chk;
    assign o_stat.drop_last = (r_drop_cnt == LEN_W'(1));
    assign o_stat.out_free  = out_free;

    // window fills in order and shifts toward entry zero on every drop and on an append when full
    always_ff @(posedge i_clk) begin
        if (i_cmd.append) begin
            if (full) begin
                for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                    r_win[i] <= r_win[i+1];
                end
                r_win[WINDOW_DEPTH-1] <= i_rx_byte;
            end else begin
                r_win[r_fill[IDX_W-1:0]] <= i_rx_byte;
            end
        end else if (i_cmd.drop_one) begin
            for (int i = 0; i < WINDOW_DEPTH - 1; i++) begin
                r_win[i] <= r_win[i+1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill       <= '0;
            r_drop_cnt   <= '0;
            r_in_session <= 1'b0;
        end else begin
            if (i_cmd.append) begin
                if (!full) r_fill <= r_fill + FILL_W'(1);
            end else if (i_cmd.drop_one) begin
                r_fill <= r_fill - FILL_W'(1);
            end
            if (i_cmd.load_cnt) begin
                r_drop_cnt <= flen_m1;
            end else if (i_cmd.dec_cnt) begin
                r_drop_cnt <= r_drop_cnt - LEN_W'(1);
            end
            if (i_cmd.capture) begin
                if (kind == KIND_START) begin
                    r_in_session <= 1'b1;
                end else if (kind == KIND_END) begin
                    r_in_session <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_marker <= START_RESET;
            r_end_marker   <= END_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_START_MARKER: r_start_marker <= i_cfg_data;
                CFG_END_MARKER:   r_end_marker   <= i_cfg_data;
                default:          r_start_marker <= r_start_marker;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_pend_a    <= word_a;
            r_pend_b    <= word_b;
            r_pend_kind <= kind;
        end
        if (i_cmd.load_out) begin
            r_out_a       <= r_pend_a;
            r_out_b       <= r_pend_b;
            r_out_present <= (r_pend_b != '0);
            r_out_kind    <= r_pend_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_first_word     = r_out_a;
    assign o_second_word    = r_out_b;
    assign o_second_present = r_out_present;
    assign o_frame_kind     = r_out_kind;

endmodule

`default_nettype wire

[hdl/serial_can_frame_deframer_top.sv]
// top level of the serial can frame deframer
//
// input channel: one received byte per transfer on i_rx_byte (i_valid / o_stall)
// output channel: one decoded frame per transfer (o_valid / i_stall) with two
//   little-endian data words, a nonzero flag for the second word and a kind tag
//   (start marker, end marker, data in session, data outside session)
// config channel: i_cfg_valid / o_cfg_ready, index 0 start marker, 1 end marker;
//   o_cfg_ready is always high, writes are meant for idle periods only
// each byte is appended and then the window is checked, again after every dropped
//   leading byte; dropped bytes and removed frames leave the window through the
//   one-byte-per-cycle window shifter, and an item can also wait on a stalled
//   output
// a finished frame is loaded into the output register from the emit state once
//   that register is free; o_stall stays high while a byte is being processed and while
//   a new result waits for a full output register held by i_stall
// a result in the output register does not block the next byte
// reset (synchronous, active low) empties the window, ends any session,
//   clears the output valid flag and restores both markers
`default_nettype none

module serial_can_frame_deframer_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_valid,
    output logic                                o_stall,
    input  wire logic [7:0]                     i_rx_byte,
    output logic                                o_valid,
    input  wire logic                           i_stall,
    output logic signed [scfd_pkg::WORD_W-1:0]  o_first_word,
    output logic signed [scfd_pkg::WORD_W-1:0]  o_second_word,
    output logic                                o_second_present,
    output logic [1:0]                          o_frame_kind,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [scfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic signed [scfd_pkg::WORD_W-1:0] i_cfg_data
);
    import scfd_pkg::*;

    t_cmd              cmd;
    t_stat             stat;
    logic [WORD_W-1:0] first_word;
    logic [WORD_W-1:0] second_word;

    assign o_cfg_ready = 1'b1;

    scfd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    scfd_dpath u_dpath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_rx_byte        (i_rx_byte),
        .i_cfg_valid      (i_cfg_valid),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (unsigned'(i_cfg_data)),
        .i_stall          (i_stall),
        .i_cmd            (cmd),
        .o_stat           (stat),
        .o_valid          (o_valid),
        .o_first_word     (first_word),
        .o_second_word    (second_word),
        .o_second_present (o_second_present),
        .o_frame_kind     (o_frame_kind)
    );

    assign o_first_word  = signed'(first_word);
    assign o_second_word = signed'(second_word);

endmodule

`default_nettype wire

[hdl/scfd_checker.sv]
// port-level assertions for the frame deframer and their bind
`default_nettype none

module scfd_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_valid,
    input wire logic                           o_stall,
    input wire logic                           o_valid,
    input wire logic                           i_stall,
    input wire logic [scfd_pkg::WORD_W-1:0]    o_first_word,
    input wire logic [scfd_pkg::WORD_W-1:0]    o_second_word,
    input wire logic                           o_second_present
);
    import scfd_pkg::*;

    // output holds while the receiver stalls
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_first_word) && $stable(o_second_word))
        else $error("output changed while stalled");

    // flag matches the second word
    a_present: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_second_present == (o_second_word != '0)))
        else $error("second_present does not match second_word");

    // o_stall is high in the cycle after every accepted byte
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("byte accepted without a processing cycle");

    // an accepted byte must be processed before a new result can appear
    a_no_instant_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid)
        else $error("result appeared right after a byte transfer");

endmodule

bind serial_can_frame_deframer_top scfd_checker u_scfd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_valid          (i_valid),
    .o_stall          (o_stall),
    .o_valid          (o_valid),
    .i_stall          (i_stall),
    .o_first_word     (o_first_word),
    .o_second_word    (o_second_word),
    .o_second_present (o_second_present)
);

`default_nettype wire

[dv/scfd_scoreboard_pkg.sv]
// frame scoreboard for the serial can frame deframer: byte window decoder and result checks
`timescale 1ns / 1ps

package scfd_tb_pkg;

    import scfd_pkg::*;

    typedef struct {
        logic [WORD_W-1:0] first_word;
        logic [WORD_W-1:0] second_word;
        logic              second_present;
        t_kind             frame_kind;
    } t_frame_result;

    class frame_scoreboard;

        logic [7:0]        win [WINDOW_DEPTH];
        int                fill;
        bit                in_session;
        logic [WORD_W-1:0] start_marker;
        logic [WORD_W-1:0] end_marker;
        t_frame_result     expected_frames [$];
        int                errors;

        function new();
            foreach (win[i]) win[i] = 8'h00;
            fill         = 0;
            in_session   = 1'b0;
            start_marker = START_RESET;
            end_marker   = END_RESET;
            errors       = 0;
        endfunction

        function void set_marker(logic [CFG_IDX_W-1:0] idx, logic [WORD_W-1:0] value);
            if (idx == CFG_START_MARKER) begin
                start_marker = value;
            end else if (idx == CFG_END_MARKER) begin
                end_marker = value;
            end
        endfunction

        function void shift_out(int count);
            if (count >= fill) begin
                fill = 0;
                return;
            end
            for (int i = 0; i < fill - count; i++) win[i] = win[i + count];
            fill -= count;
        endfunction

        // append one accepted byte and decode whatever frame it completes
        function void note_byte(logic [7:0] rx);
            logic [3:0]        dlc;
            int                flen;
            logic [WORD_W-1:0] w0;
            logic [WORD_W-1:0] w1;
            t_frame_result     res;
            if (fill >= WINDOW_DEPTH) shift_out(1);
            win[fill] = rx;
            fill++;
            while (fill >= MIN_CHECK_FILL && fill >= 2) begin
                if (win[0] != SOF_BYTE) begin
                    shift_out(1);
                    continue;
                end
                if ((win[1] & TYPE_MASK) != TYPE_MASK) begin
                    shift_out(1);
                    continue;
                end
                dlc  = 4'(win[1] & LEN_MASK);
                flen = int'(HDR_LEN) + int'(dlc);
                if (fill < flen) begin
                    if (fill >= WINDOW_DEPTH) begin
                        shift_out(1);
                        continue;
                    end
                    break;
                end
                if (win[flen - 1] != EOF_BYTE) begin
                    shift_out(1);
                    continue;
                end
                if (dlc < MIN_DLC) begin
                    shift_out(flen);
                    continue;
                end
                w0 = {win[7], win[6], win[5], win[4]};
                w1 = {win[11], win[10], win[9], win[8]};
                shift_out(flen);
                if (w0 == start_marker) begin
                    in_session     = 1'b1;
                    res.frame_kind = KIND_START;
                end else if (w0 == end_marker) begin
                    in_session     = 1'b0;
                    res.frame_kind = KIND_END;
                end else begin
                    res.frame_kind = in_session ? KIND_IN_SES : KIND_OUT_SES;
                end
                res.first_word     = w0;
                res.second_word    = w1;
                res.second_present = (w1 != '0);
                expected_frames = {expected_frames, res};
                break;
            end
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 100) $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_frame(logic [WORD_W-1:0] first_word, logic [WORD_W-1:0] second_word,
                         logic second_present, logic [1:0] frame_kind);
            t_frame_result want;
            if (expected_frames.size() == 0) begin
                report_mismatch("frame out with none pending");
                return;
            end
            want = expected_frames.pop_front();
            if (first_word !== want.first_word)
                report_mismatch($sformatf("first_word %h, want %h", first_word, want.first_word));
            if (second_word !== want.second_word)
                report_mismatch($sformatf("second_word %h, want %h", second_word,
                                          want.second_word));
            if (second_present !== want.second_present)
                report_mismatch($sformatf("second_present %b, want %b", second_present,
                                          want.second_present));
            if (frame_kind !== want.frame_kind)
                report_mismatch($sformatf("frame_kind %0d, want %s", frame_kind,
                                          want.frame_kind.name()));
        endtask

        task check_drained();
            if (expected_frames.size() != 0)
                report_mismatch($sformatf("%0d frames never came out", expected_frames.size()));
        endtask

    endclass

endpackage

[dv/tb_top.sv]
// testbench top for the serial can frame deframer: byte and frame traffic, config phases
`timescale 1ns / 1ps

module tb_top;

    import scfd_pkg::*;
    import scfd_tb_pkg::*;

    localparam int CYCLE_LIMIT   = 1000000;
    localparam int SETTLE_CYCLES = 48;
    localparam int PHASE_BYTES   = 170;
    localparam int NUM_PHASES    = 6;
    localparam int MAX_FRAME     = 20;

    typedef enum int {
        FLAW_NONE = 0,
        FLAW_TYPE = 1,
        FLAW_EOF  = 2,
        FLAW_CUT  = 3
    } t_flaw;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_stall;
    logic [7:0]           i_rx_byte = 8'h00;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    logic [WORD_W-1:0]    o_first_word;
    logic [WORD_W-1:0]    o_second_word;
    logic                 o_second_present;
    logic [1:0]           o_frame_kind;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_START_MARKER;
    logic [WORD_W-1:0]    i_cfg_data = '0;

    frame_scoreboard sb;
    bit              sender_steady;
    int              phase_bytes;

    serial_can_frame_deframer_top i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_rx_byte        (i_rx_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_first_word     (o_first_word),
        .o_second_word    (o_second_word),
        .o_second_present (o_second_present),
        .o_frame_kind     (o_frame_kind),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 93) return $urandom_range(4, 10);
        return $urandom_range(20, 50);
    endfunction

    function automatic logic [WORD_W-1:0] pick_first_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 22) return sb.start_marker;
        if (r < 40) return sb.end_marker;
        if (r < 48) return 32'h0000_0000;
        if (r < 54) return 32'hFFFF_FFFF;
        if (r < 58) return 32'h8000_0000;
        return $urandom;
    endfunction

    function automatic logic [WORD_W-1:0] pick_second_word();
        int r;
        r = $urandom_range(0, 99);
        if (r < 20) return 32'h0000_0000;
        if (r < 25) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 7);
        if (r < 2) return SOF_BYTE;
        if (r == 2) return EOF_BYTE;
        return 8'($urandom);
    endfunction

    task automatic send_byte(input logic [7:0] rx);
        int gap;
        gap = (sender_steady || $urandom_range(0, 1) == 1) ? 0 : idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_byte(rx);
        phase_bytes++;
    endtask

    task automatic send_frame(input logic [3:0] dlc, input logic [WORD_W-1:0] w0,
                              input logic [WORD_W-1:0] w1, input t_flaw flaw);
        logic [7:0] frame_b [MAX_FRAME];
        logic [7:0] type_byte;
        logic [7:0] bad;
        int         n;
        int         keep;
        n = 0;
        type_byte = {2'b11, 2'($urandom_range(0, 3)), dlc};
        if (flaw == FLAW_TYPE) type_byte[7:6] = 2'($urandom_range(0, 2));
        frame_b[n] = SOF_BYTE;
        n++;
        frame_b[n] = type_byte;
        n++;
        frame_b[n] = 8'($urandom);
        n++;
        frame_b[n] = 8'($urandom);
        n++;
        for (int i = 0; i < int'(dlc); i++) begin
            if (i < 4) frame_b[n] = w0[8*i +: 8];
            else if (i < 8) frame_b[n] = w1[8*(i-4) +: 8];
            else frame_b[n] = 8'($urandom);
            n++;
        end
        if (flaw == FLAW_EOF) begin
            do bad = 8'($urandom); while (bad == EOF_BYTE);
            frame_b[n] = bad;
        end else begin
            frame_b[n] = EOF_BYTE;
        end
        n++;
        keep = (flaw == FLAW_CUT) ? $urandom_range(1, n - 1) : n;
        for (int i = 0; i < keep; i++) send_byte(frame_b[i]);
    endtask

    task automatic send_random_chunk();
        int r;
        int n;
        r = $urandom_range(0, 99);
        if (r < 68) begin
            send_frame(4'($urandom_range(8, 15)), pick_first_word(), pick_second_word(),
                       FLAW_NONE);
        end else if (r < 78) begin
            send_frame(4'($urandom_range(0, 7)), $urandom, $urandom, FLAW_NONE);
        end else if (r < 88) begin
            send_frame(4'($urandom_range(0, 15)), pick_first_word(), $urandom,
                       t_flaw'($urandom_range(1, 3)));
        end else begin
            n = $urandom_range(1, 8);
            repeat (n) send_byte(noise_byte());
        end
    endtask

    // drain all pending frames, then let the window scan finish
    task automatic settle();
        i_valid <= 1'b0;
        while (sb.expected_frames.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_marker(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        sb.set_marker(idx, value);
    endtask

    initial begin : stall_gen
        int quiet_len;
        forever begin
            quiet_len = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                    : $urandom_range(1, 30);
            repeat (quiet_len) @(posedge i_clk);
            i_stall <= 1'b1;
            repeat (idle_len()) @(posedge i_clk);
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_frame(o_first_word, o_second_word, o_second_present, o_frame_kind);
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("status: fail");
        $finish;
    end

    initial begin : stimulus
        logic [WORD_W-1:0] start_plan [NUM_PHASES];
        logic [WORD_W-1:0] end_plan   [NUM_PHASES];
        sb = new();
        start_plan = '{32'h0000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                       32'h0000_0000, START_RESET};
        end_plan   = '{32'h0000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001,
                       32'h0000_0000, END_RESET};
        sender_steady = 1'b0;
        phase_bytes   = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed frames under the reset markers
        send_frame(4'd8, START_RESET, 32'hFFFF_FFFF, FLAW_NONE);
        send_frame(4'd15, 32'h0000_0000, 32'h0000_0000, FLAW_NONE);
        send_frame(4'd8, 32'hFFFF_FFFF, 32'h0000_0001, FLAW_NONE);
        send_frame(4'd0, 32'h0, 32'h0, FLAW_NONE);
        send_frame(4'd8, END_RESET, 32'h0000_0000, FLAW_NONE);
        send_frame(4'd9, 32'h8000_0000, 32'h7FFF_FFFF, FLAW_NONE);
        send_byte(8'h00);
        send_byte(8'hFF);
        // long header whose frame swallows a full frame and a short one, ending on the short one's end byte
        send_byte(SOF_BYTE);
        send_byte(8'hCF);
        send_frame(4'd8, 32'h1234_5678, 32'h9ABC_DEF0, FLAW_NONE);
        send_frame(4'd0, 32'h0, 32'h0, FLAW_NONE);
        send_frame(4'd8, 32'h0BAD_F00D, 32'h0000_0002, FLAW_EOF);
        send_frame(4'd8, 32'h0BAD_F00D, 32'h0000_0003, FLAW_TYPE);
        send_frame(4'd10, 32'h5555_AAAA, 32'hAAAA_5555, FLAW_NONE);

        phase_bytes = 0;
        while (phase_bytes < PHASE_BYTES) send_random_chunk();

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            if (p == 4) begin
                start_plan[p] = $urandom;
                end_plan[p]   = ($urandom_range(0, 1) == 1) ? start_plan[p] : 32'($urandom);
            end
            write_marker(CFG_START_MARKER, start_plan[p]);
            write_marker(CFG_END_MARKER, end_plan[p]);
            sender_steady = (p % 3 == 1);
            phase_bytes   = 0;
            while (phase_bytes < PHASE_BYTES) send_random_chunk();
        end

        settle();
        sb.check_drained();
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
